/* sv/ccas_pkg.sv */
// ----------------------------------------------------------------------------
// ccas_pkg: shared types and constants
// Operation codes, register indexes, neighbor directions, field widths and the
// status bundle that the generation engine hands to the top level.
// ----------------------------------------------------------------------------
package ccas_pkg;

	// Field widths of the ports.
	localparam int OP_W         = 2;
	localparam int COORD_W      = 7;
	localparam int VALUE_W      = 8;
	localparam int COUNT_W      = 15;
	localparam int GEN_W        = 16;
	localparam int NUM_STATES_W = 9;
	localparam int CFG_IDX_W    = 2;
	localparam int SIZE_W       = 8;

	// Register reset values.
	localparam logic [NUM_STATES_W-1:0] NUM_STATES_RST  = 9'd16;
	localparam logic [SIZE_W-1:0]       ACTIVE_SIZE_RST = 8'd128;

	// The changed-cell count saturates here.
	localparam logic [COUNT_W-1:0] COUNT_MAX = 15'h7fff;

	// Input operation codes.
	typedef enum logic [OP_W-1:0] {
		OP_LOAD = 2'd0,
		OP_STEP = 2'd1,
		OP_READ = 2'd2
	} ccas_op_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NUM_STATES  = 2'd0,
		CFG_HEX_MODE    = 2'd1,
		CFG_ACTIVE_COLS = 2'd2,
		CFG_ACTIVE_ROWS = 2'd3
	} ccas_cfg_t;

	// Neighbor slots. Square mode uses the first four (N, E, S, W),
	// hex mode all six.
	typedef enum logic [2:0] {
		DIR_NE = 3'd0,
		DIR_E  = 3'd1,
		DIR_SE = 3'd2,
		DIR_W  = 3'd3,
		DIR_SW = 3'd4,
		DIR_NW = 3'd5
	} ccas_dir_t;

	// Status from the generation engine.
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic mark;
		logic done;
	} ccas_eng_stat_t;

endpackage

/* sv/cyclic_cellular_automaton_step.sv */
// ----------------------------------------------------------------------------
// cyclic_cellular_automaton_step: cyclic cellular automaton engine
// Toroidal grid of cell states held in two grid memories that swap roles
// each generation, with a changed mark per cell.
//
// Channel  Handshake              Payload
// cfg      cfg_we                 cfg_index, cfg_data
// in       in_valid / in_stall    op, col, row, cell_value
// out      out_valid / out_stall  cell_value_out, changed, changed_count, generation
//
// A load is written on transfer; a read's data passes the grid's registered
// read port and then the output register. A step walks all MAX_ROWS x MAX_COLS
// cells through the grid's single read port, reading each active cell and its
// neighbors, waiting on the remainder unit when the successor needs it.
// After reset a clearing pass zeroes the changed marks; in_stall is high
// meanwhile.
// A finished result waits in the output register while loads go on.
// ----------------------------------------------------------------------------
module cyclic_cellular_automaton_step
	import ccas_pkg::*;
#(
	parameter int MAX_COLS   = 128,
	parameter int MAX_ROWS   = 128,
	parameter int STATE_BITS = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [NUM_STATES_W-1:0] cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [OP_W-1:0]         op,
	input  logic [COORD_W-1:0]      col,
	input  logic [COORD_W-1:0]      row,
	input  logic [VALUE_W-1:0]      cell_value,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [VALUE_W-1:0]      cell_value_out,
	output logic                    changed,
	output logic [COUNT_W-1:0]      changed_count,
	output logic [GEN_W-1:0]        generation
);

	localparam int CW  = $clog2(MAX_COLS);
	localparam int RW  = $clog2(MAX_ROWS);
	localparam int AW  = CW + RW;
	localparam int CCW = $clog2(MAX_COLS + 1);
	localparam int RCW = $clog2(MAX_ROWS + 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_GEN,
		ST_DONE
	} top_state_t;

	// Configuration registers.
	logic [NUM_STATES_W-1:0] num_states_q;
	logic                    hex_mode_q;
	logic [SIZE_W-1:0]       active_cols_q;
	logic [SIZE_W-1:0]       active_rows_q;

	top_state_t              state_q;
	logic [AW-1:0]           clr_q;
	logic                    bank_q;
	logic [GEN_W-1:0]        gen_q;
	logic                    in_grid_q;
	logic                    out_valid_q;
	logic [VALUE_W-1:0]      cell_value_out_q;
	logic                    changed_q;
	logic [COUNT_W-1:0]      changed_count_q;
	logic [GEN_W-1:0]        generation_q;

	logic [NUM_STATES_W-1:0] n_eff;
	logic [RCW-1:0]          rows_eff;
	logic [CCW-1:0]          cols_eff;
	logic                    accept;
	logic                    in_grid;
	logic [AW-1:0]           host_addr;
	logic [STATE_BITS-1:0]   ld_data;
	logic                    ld_we;
	logic                    host_rd;
	logic                    out_free;

	logic [AW-1:0]           eng_rd_addr;
	logic [AW-1:0]           eng_wr_addr;
	logic [STATE_BITS-1:0]   eng_wr_data;
	ccas_eng_stat_t          eng_stat;
	logic [COUNT_W-1:0]      eng_count;

	logic [AW-1:0]           grid_rd_addr;
	logic                    grid_rd_en;
	logic                    g0_we;
	logic                    g1_we;
	logic [AW-1:0]           g0_waddr;
	logic [AW-1:0]           g1_waddr;
	logic [STATE_BITS-1:0]   g0_wdata;
	logic [STATE_BITS-1:0]   g1_wdata;
	logic [STATE_BITS-1:0]   g0_rdata;
	logic [STATE_BITS-1:0]   g1_rdata;
	logic [STATE_BITS-1:0]   cur_data;
	logic                    mk_we;
	logic [AW-1:0]           mk_waddr;
	logic                    mk_wdata;
	logic                    mk_rdata;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_states_q  <= NUM_STATES_RST;
			hex_mode_q    <= 1'b0;
			active_cols_q <= ACTIVE_SIZE_RST;
			active_rows_q <= ACTIVE_SIZE_RST;
		end else if (cfg_we) begin
			case (ccas_cfg_t'(cfg_index))
				CFG_NUM_STATES:  num_states_q  <= cfg_data;
				CFG_HEX_MODE:    hex_mode_q    <= cfg_data[0];
				CFG_ACTIVE_COLS: active_cols_q <= cfg_data[SIZE_W-1:0];
				CFG_ACTIVE_ROWS: active_rows_q <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective state count and active size: zero acts as one, sizes clamp.
	always_comb begin
		n_eff = (num_states_q == '0) ? NUM_STATES_W'(1) : num_states_q;
		if (active_cols_q == '0) begin
			cols_eff = CCW'(1);
		end else if (32'(active_cols_q) > MAX_COLS) begin
			cols_eff = CCW'(MAX_COLS);
		end else begin
			cols_eff = CCW'(active_cols_q);
		end
		if (active_rows_q == '0) begin
			rows_eff = RCW'(1);
		end else if (32'(active_rows_q) > MAX_ROWS) begin
			rows_eff = RCW'(MAX_ROWS);
		end else begin
			rows_eff = RCW'(active_rows_q);
		end
	end

	// Input decode.
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		accept    = in_valid && !in_stall;
		in_grid   = (32'(col) < MAX_COLS) && (32'(row) < MAX_ROWS);
		host_addr = {RW'(row), CW'(col)};
		ld_data   = STATE_BITS'(cell_value);
		ld_we     = accept && (ccas_op_t'(op) == OP_LOAD) && in_grid;
		host_rd   = accept && (ccas_op_t'(op) == OP_READ);
		out_free  = !out_valid_q || !out_stall;
	end

	// Grid port steering: loads and reads use the current bank, the engine
	// reads the current bank and writes the other one.
	always_comb begin
		grid_rd_en   = host_rd || eng_stat.rd_en;
		grid_rd_addr = (state_q == ST_GEN) ? eng_rd_addr : host_addr;
		g0_we        = bank_q ? eng_stat.wr_en : ld_we;
		g0_waddr     = bank_q ? eng_wr_addr : host_addr;
		g0_wdata     = bank_q ? eng_wr_data : ld_data;
		g1_we        = bank_q ? ld_we : eng_stat.wr_en;
		g1_waddr     = bank_q ? host_addr : eng_wr_addr;
		g1_wdata     = bank_q ? ld_data : eng_wr_data;
		cur_data     = bank_q ? g1_rdata : g0_rdata;
		mk_we        = (state_q == ST_CLEAR) || eng_stat.wr_en;
		mk_waddr     = (state_q == ST_CLEAR) ? clr_q : eng_wr_addr;
		mk_wdata     = (state_q == ST_CLEAR) ? 1'b0 : eng_stat.mark;
	end

	ccas_ram #(
		.WIDTH  (STATE_BITS),
		.ADDR_W (AW)
	) u_grid0 (
		.clk     (clk),
		.wr_en   (g0_we),
		.wr_addr (g0_waddr),
		.wr_data (g0_wdata),
		.rd_en   (grid_rd_en),
		.rd_addr (grid_rd_addr),
		.rd_data (g0_rdata)
	);

	ccas_ram #(
		.WIDTH  (STATE_BITS),
		.ADDR_W (AW)
	) u_grid1 (
		.clk     (clk),
		.wr_en   (g1_we),
		.wr_addr (g1_waddr),
		.wr_data (g1_wdata),
		.rd_en   (grid_rd_en),
		.rd_addr (grid_rd_addr),
		.rd_data (g1_rdata)
	);

	ccas_ram #(
		.WIDTH  (1),
		.ADDR_W (AW)
	) u_marks (
		.clk     (clk),
		.wr_en   (mk_we),
		.wr_addr (mk_waddr),
		.wr_data (mk_wdata),
		.rd_en   (host_rd),
		.rd_addr (host_addr),
		.rd_data (mk_rdata)
	);

	ccas_eng #(
		.MAX_COLS   (MAX_COLS),
		.MAX_ROWS   (MAX_ROWS),
		.STATE_BITS (STATE_BITS)
	) u_eng (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && (ccas_op_t'(op) == OP_STEP)),
		.hex      (hex_mode_q),
		.n_eff    (n_eff),
		.rows_eff (rows_eff),
		.cols_eff (cols_eff),
		.rd_data  (cur_data),
		.rd_addr  (eng_rd_addr),
		.wr_addr  (eng_wr_addr),
		.wr_data  (eng_wr_data),
		.stat     (eng_stat),
		.count    (eng_count)
	);

	// Control sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			bank_q      <= 1'b0;
			gen_q       <= '0;
			in_grid_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (ccas_op_t'(op))
							OP_READ: begin
								in_grid_q <= in_grid;
								state_q   <= ST_READ;
							end
							OP_STEP: begin
								state_q <= ST_GEN;
							end
							default: ;
						endcase
					end
				end
				ST_READ: begin
					if (out_free) begin
						cell_value_out_q <= in_grid_q ? VALUE_W'(cur_data) : '0;
						changed_q        <= in_grid_q && mk_rdata;
						changed_count_q  <= '0;
						generation_q     <= gen_q;
						out_valid_q      <= 1'b1;
						state_q          <= ST_IDLE;
					end
				end
				ST_GEN: begin
					if (eng_stat.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						cell_value_out_q <= '0;
						changed_q        <= 1'b0;
						changed_count_q  <= eng_count;
						generation_q     <= gen_q + GEN_W'(1);
						gen_q            <= gen_q + GEN_W'(1);
						bank_q           <= !bank_q;
						out_valid_q      <= 1'b1;
						state_q          <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign cell_value_out = cell_value_out_q;
	assign changed        = changed_q;
	assign changed_count  = changed_count_q;
	assign generation     = generation_q;

endmodule

/* sv/ccas_ram.sv */
// ----------------------------------------------------------------------------
// ccas_ram: simple dual-port memory
// One write port and one read port with registered read data that holds
// its value while no read is issued.
// ----------------------------------------------------------------------------
module ccas_ram #(
	parameter int WIDTH  = 8,
	parameter int ADDR_W = 14
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [2**ADDR_W];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* sv/ccas_mod.sv */
// ----------------------------------------------------------------------------
// ccas_mod: iterative remainder unit
// Restoring division that produces dividend mod divisor, one quotient bit
// per cycle. A start pulse loads the operands; done pulses with the result.
// ----------------------------------------------------------------------------
module ccas_mod
	import ccas_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [NUM_STATES_W-1:0] dividend,
	input  logic [NUM_STATES_W-1:0] divisor,
	output logic                    done,
	output logic [NUM_STATES_W-1:0] rem
);

	localparam int CNT_W = $clog2(NUM_STATES_W + 1);

	logic [NUM_STATES_W-1:0] rem_q;
	logic [NUM_STATES_W-1:0] dvd_q;
	logic [NUM_STATES_W-1:0] div_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    done_q;
	logic [NUM_STATES_W:0]   shifted;
	logic [NUM_STATES_W-1:0] trial;

	// One restoring step: bring down the next dividend bit and subtract.
	always_comb begin
		shifted = {rem_q, dvd_q[NUM_STATES_W-1]};
		if (shifted >= {1'b0, div_q}) begin
			trial = NUM_STATES_W'(shifted - {1'b0, div_q});
		end else begin
			trial = NUM_STATES_W'(shifted);
		end
	end

	// Step counter and working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q <= '0;
				dvd_q <= dividend;
				div_q <= divisor;
				cnt_q <= CNT_W'(NUM_STATES_W);
			end else if (cnt_q != '0) begin
				rem_q <= trial;
				dvd_q <= dvd_q << 1;
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

/* sv/ccas_nbr.sv */
// ----------------------------------------------------------------------------
// ccas_nbr: neighbor address generator
// Maps a cell and a neighbor slot to the neighbor's column and row on the
// torus, for the square and the offset hexagonal layouts.
// ----------------------------------------------------------------------------
module ccas_nbr
	import ccas_pkg::*;
#(
	parameter int MAX_COLS = 128,
	parameter int MAX_ROWS = 128
) (
	input  logic [$clog2(MAX_ROWS)-1:0]   r,
	input  logic [$clog2(MAX_COLS)-1:0]   c,
	input  ccas_dir_t                     dir,
	input  logic                          hex,
	input  logic [$clog2(MAX_ROWS+1)-1:0] rows_eff,
	input  logic [$clog2(MAX_COLS+1)-1:0] cols_eff,
	output logic [$clog2(MAX_ROWS)-1:0]   nr,
	output logic [$clog2(MAX_COLS)-1:0]   nc
);

	localparam int CW  = $clog2(MAX_COLS);
	localparam int RW  = $clog2(MAX_ROWS);
	localparam int CCW = $clog2(MAX_COLS + 1);
	localparam int RCW = $clog2(MAX_ROWS + 1);

	logic [RW-1:0] up;
	logic [RW-1:0] dn;
	logic [CW-1:0] lf;
	logic [CW-1:0] rt;
	logic          odd;

	// Wrapped row and column offsets.
	always_comb begin
		up  = (r == '0) ? RW'(rows_eff - RCW'(1)) : r - RW'(1);
		dn  = (RCW'(r) + RCW'(1) == rows_eff) ? '0 : r + RW'(1);
		lf  = (c == '0) ? CW'(cols_eff - CCW'(1)) : c - CW'(1);
		rt  = (CCW'(c) + CCW'(1) == cols_eff) ? '0 : c + CW'(1);
		odd = r[0];
	end

	// Slot selection. In square mode NE and SE stand for N and S.
	always_comb begin
		case (dir)
			DIR_NE: begin
				nc = hex ? (odd ? c : rt) : c;
				nr = up;
			end
			DIR_E: begin
				nc = rt;
				nr = r;
			end
			DIR_SE: begin
				nc = hex ? (odd ? c : rt) : c;
				nr = dn;
			end
			DIR_W: begin
				nc = lf;
				nr = r;
			end
			DIR_SW: begin
				nc = odd ? lf : c;
				nr = dn;
			end
			DIR_NW: begin
				nc = odd ? lf : c;
				nr = up;
			end
			default: begin
				nc = c;
				nr = r;
			end
		endcase
	end

endmodule

/* sv/ccas_eng.sv */
// ----------------------------------------------------------------------------
// ccas_eng: generation engine
// Walks every cell of the grid, reads the cell and, for an active cell, its
// neighbors one per cycle through the current grid's read port, compares each
// neighbor against the successor and writes the new state and changed mark.
// ----------------------------------------------------------------------------
module ccas_eng
	import ccas_pkg::*;
#(
	parameter int MAX_COLS   = 128,
	parameter int MAX_ROWS   = 128,
	parameter int STATE_BITS = 8
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             start,
	input  logic                                             hex,
	input  logic [NUM_STATES_W-1:0]                          n_eff,
	input  logic [$clog2(MAX_ROWS+1)-1:0]                    rows_eff,
	input  logic [$clog2(MAX_COLS+1)-1:0]                    cols_eff,
	input  logic [STATE_BITS-1:0]                            rd_data,
	output logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0]     rd_addr,
	output logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0]     wr_addr,
	output logic [STATE_BITS-1:0]                            wr_data,
	output ccas_eng_stat_t                                   stat,
	output logic [COUNT_W-1:0]                               count
);

	localparam int CW  = $clog2(MAX_COLS);
	localparam int RW  = $clog2(MAX_ROWS);
	localparam int CCW = $clog2(MAX_COLS + 1);
	localparam int RCW = $clog2(MAX_ROWS + 1);

	typedef enum logic [2:0] {
		E_IDLE,
		E_SELF,
		E_SWAIT,
		E_MOD,
		E_NBR,
		E_DRAIN
	} eng_state_t;

	eng_state_t              state_q;
	logic [RW-1:0]           r_q;
	logic [CW-1:0]           c_q;
	ccas_dir_t               k_q;
	logic [STATE_BITS-1:0]   self_q;
	logic [NUM_STATES_W-1:0] succ_q;
	logic                    hit_q;
	logic                    cmp_v_s1;
	logic [COUNT_W-1:0]      count_q;
	logic                    done_q;

	logic [RW-1:0]           nr;
	logic [CW-1:0]           nc;
	logic                    active;
	logic [NUM_STATES_W-1:0] succ_fast;
	logic                    match;
	logic                    hit_f;
	ccas_dir_t               last_dir;
	logic                    last_cell;
	logic                    advance;
	logic                    mod_start;
	logic                    mod_done;
	logic [NUM_STATES_W-1:0] mod_rem;

	ccas_nbr #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_nbr (
		.r        (r_q),
		.c        (c_q),
		.dir      (k_q),
		.hex      (hex),
		.rows_eff (rows_eff),
		.cols_eff (cols_eff),
		.nr       (nr),
		.nc       (nc)
	);

	ccas_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (succ_fast),
		.divisor  (n_eff),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// Per-cell decode: active area, successor, neighbor compare.
	always_comb begin
		active    = (RCW'(r_q) < rows_eff) && (CCW'(c_q) < cols_eff);
		succ_fast = NUM_STATES_W'(rd_data) + NUM_STATES_W'(1);
		match     = cmp_v_s1 && (NUM_STATES_W'(rd_data) == succ_q);
		hit_f     = hit_q | match;
		last_dir  = hex ? DIR_NW : DIR_W;
		last_cell = (r_q == RW'(MAX_ROWS - 1)) && (c_q == CW'(MAX_COLS - 1));
		advance   = ((state_q == E_SWAIT) && !active) || (state_q == E_DRAIN);
	end

	// Memory requests for the current phase.
	always_comb begin
		rd_addr     = {r_q, c_q};
		wr_addr     = {r_q, c_q};
		wr_data     = self_q;
		stat.rd_en  = 1'b0;
		stat.wr_en  = 1'b0;
		stat.mark   = 1'b0;
		stat.done   = done_q;
		mod_start   = 1'b0;
		case (state_q)
			E_SELF: begin
				stat.rd_en = 1'b1;
			end
			E_SWAIT: begin
				if (!active) begin
					// Cells outside the active area are copied and unmarked.
					stat.wr_en = 1'b1;
					wr_data    = rd_data;
				end else if (succ_fast > n_eff) begin
					mod_start = 1'b1;
				end
			end
			E_NBR: begin
				stat.rd_en = 1'b1;
				rd_addr    = {nr, nc};
			end
			E_DRAIN: begin
				stat.wr_en = 1'b1;
				wr_data    = hit_f ? succ_q[STATE_BITS-1:0] : self_q;
				stat.mark  = hit_f && (succ_q != NUM_STATES_W'(self_q));
			end
			default: ;
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= E_IDLE;
			r_q      <= '0;
			c_q      <= '0;
			k_q      <= DIR_NE;
			hit_q    <= 1'b0;
			cmp_v_s1 <= 1'b0;
			count_q  <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q   <= 1'b0;
			cmp_v_s1 <= 1'b0;
			if (cmp_v_s1) begin
				hit_q <= hit_f;
			end
			case (state_q)
				E_IDLE: begin
					if (start) begin
						r_q     <= '0;
						c_q     <= '0;
						count_q <= '0;
						state_q <= E_SELF;
					end
				end
				E_SELF: begin
					state_q <= E_SWAIT;
				end
				E_SWAIT: begin
					if (active) begin
						self_q <= rd_data;
						k_q    <= DIR_NE;
						hit_q  <= 1'b0;
						if (succ_fast < n_eff) begin
							succ_q  <= succ_fast;
							state_q <= E_NBR;
						end else if (succ_fast == n_eff) begin
							succ_q  <= '0;
							state_q <= E_NBR;
						end else begin
							state_q <= E_MOD;
						end
					end
				end
				E_MOD: begin
					if (mod_done) begin
						succ_q  <= mod_rem;
						state_q <= E_NBR;
					end
				end
				E_NBR: begin
					cmp_v_s1 <= 1'b1;
					if (k_q == last_dir) begin
						state_q <= E_DRAIN;
					end else begin
						k_q <= ccas_dir_t'(k_q + 3'd1);
					end
				end
				E_DRAIN: begin
					if (stat.mark && (count_q != COUNT_MAX)) begin
						count_q <= count_q + COUNT_W'(1);
					end
				end
				default: begin
					state_q <= E_IDLE;
				end
			endcase
			// Move on to the next cell, or finish after the last one.
			if (advance) begin
				if (last_cell) begin
					state_q <= E_IDLE;
					done_q  <= 1'b1;
				end else begin
					state_q <= E_SELF;
					if (c_q == CW'(MAX_COLS - 1)) begin
						c_q <= '0;
						r_q <= r_q + RW'(1);
					end else begin
						c_q <= c_q + CW'(1);
					end
				end
			end
		end
	end

	assign count = count_q;

endmodule

/* sv/ccas_check.sv */
// ----------------------------------------------------------------------------
// ccas_check: port checker
// Watches the top level's ports for handshake and result consistency, and is
// bound to every instance of the top level.
// ----------------------------------------------------------------------------
module ccas_check
	import ccas_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_stall,
	input  logic [OP_W-1:0]         op,
	input  logic                    out_valid,
	input  logic                    out_stall,
	input  logic [VALUE_W-1:0]      cell_value_out,
	input  logic                    changed,
	input  logic [COUNT_W-1:0]      changed_count,
	input  logic [GEN_W-1:0]        generation
);

	logic             seen_q;
	logic [GEN_W-1:0] last_gen_q;

	// Generation number of the last result transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= 1'b0;
			last_gen_q <= '0;
		end else if (out_valid && !out_stall) begin
			seen_q     <= 1'b1;
			last_gen_q <= generation;
		end
	end

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cell_value_out) &&
			$stable(changed) && $stable(changed_count) && $stable(generation))
		else $error("result changed while stalled");

	// A step transfer makes the block busy on the next cycle.
	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (op == OP_STEP) |=> in_stall)
		else $error("block not busy after a step transfer");

	// A marked cell comes from a read, which carries no count.
	a_read_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && changed |-> changed_count == '0)
		else $error("read result carries a changed count");

	// Generation numbers of successive results stay or advance by one.
	a_gen_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && seen_q |->
			(generation == last_gen_q) || (generation == last_gen_q + GEN_W'(1)))
		else $error("generation number out of order");

endmodule

bind cyclic_cellular_automaton_step ccas_check u_ccas_check (.*);
